FILE: hw/rtl/tql_pkg.sv
// ----------------------------------------------------------------------------
// tql_pkg
// Shared types and constants for the tabular Q-learning update block.
// ----------------------------------------------------------------------------
package tql_pkg;

  localparam int NumActions   = 11;
  localparam int DistBuckets  = 6;
  localparam int HpBuckets    = 6;
  localparam int RoundBuckets = 3;
  localparam int QRows        = DistBuckets * HpBuckets * HpBuckets * RoundBuckets;
  localparam int QDepth       = QRows * NumActions;
  localparam int AddrW        = $clog2(QDepth);
  localparam int RowW         = $clog2(QRows);
  localparam int ActW         = 4;

  // configuration register indexes
  localparam logic [1:0] CfgPlayerMax = 2'd0;
  localparam logic [1:0] CfgEnemyMax  = 2'd1;
  localparam logic [1:0] CfgLearnRate = 2'd2;
  localparam logic [1:0] CfgDiscount  = 2'd3;

  // health percentage request to the divider
  typedef struct packed {
    logic        start;
    logic [21:0] dividend;  // h*100, h <= 32767
    logic [14:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [21:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/tabular_q_learning_update_top.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_update_top
// Q-table update: quantize both situations, scan the next row for its maximum,
// then read, update and write back one entry of the on-chip Q-table.
//
//   channel | signals                  | direction | word
//   in      | in_valid_i / in_ready_o  | input     | one transition
//   out     | out_valid_o / out_ready_i| output    | one updated entry
//   cfg     | cfg_we_i                 | input     | one register write
//
// Sequence: four health divisions on one shared divider (start, 22 quotient
//   bits, done), a scan of the NumActions entries of the next row, then the
//   update, the write-back and the accept step for each word.
// Reset: a clearing pass writes zero to all QDepth (7128) table entries; no
//   word is accepted until it ends.
// Stalls: the result register holds while out_ready_i is low; the next word is
//   accepted once the result is loaded, overlapping with the wait.
// ----------------------------------------------------------------------------
module tabular_q_learning_update_top
  import tql_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [7:0]  prev_distance_i,
  input  logic signed [15:0] prev_player_hp_i,
  input  logic signed [15:0] prev_enemy_hp_i,
  input  logic signed [15:0] prev_round_i,
  input  logic [3:0]         action_taken_i,
  input  logic signed [31:0] reward_i,
  input  logic signed [7:0]  next_distance_i,
  input  logic signed [15:0] next_player_hp_i,
  input  logic signed [15:0] next_enemy_hp_i,
  input  logic signed [15:0] next_round_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_value_o,
  output logic signed [31:0] next_best_value_o,
  output logic               terminal_o,
  output logic [31:0]        update_count_o
);

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDivGo = 4'd2;
  localparam logic [3:0] StDivWt = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;
  localparam logic [3:0] StCur   = 4'd5;
  localparam logic [3:0] StTgt   = 4'd6;
  localparam logic [3:0] StDif   = 4'd7;
  localparam logic [3:0] StMul   = 4'd8;
  localparam logic [3:0] StWr    = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  logic [3:0] st_q, st_d;

  // configuration registers
  logic [14:0] pmax_q, emax_q;
  logic [15:0] lr_q, disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmax_q <= 15'd100;
      emax_q <= 15'd100;
      lr_q   <= 16'd11796;
      disc_q <= 16'd53740;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPlayerMax: pmax_q <= cfg_data_i[14:0];
        CfgEnemyMax:  emax_q <= cfg_data_i[14:0];
        CfgLearnRate: lr_q   <= cfg_data_i;
        CfgDiscount:  disc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured transition
  logic [2:0]         pd_q, nd_q;
  logic [1:0]         prd_q, nrd_q;
  logic [ActW-1:0]    act_q;
  logic signed [31:0] rew_q;
  logic               term_q;
  logic [14:0]        hp_q [4];
  logic [2:0]         hb_q [4];
  logic [1:0]         dix_q;

  function automatic logic [2:0] dist_b(logic signed [7:0] d);
    if (d < 0) return 3'd0;
    if (d > 8'sd5) return 3'(DistBuckets - 1);
    return d[2:0];
  endfunction

  function automatic logic [1:0] round_b(logic signed [15:0] r);
    if (r <= 16'sd3) return 2'd0;
    if (r <= 16'sd6) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [14:0] clamp_hp(logic signed [15:0] h, logic [14:0] mx);
    if (h < 0) return 15'd0;
    if (h[14:0] > mx) return mx;
    return h[14:0];
  endfunction

  function automatic logic [14:0] fix_max(logic [14:0] mx);
    return (mx == '0) ? 15'd1 : mx;
  endfunction

  // shared divider
  div_req_t dreq;
  div_rsp_t drsp;
  logic [14:0] dmax;

  tql_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign dmax           = fix_max(dix_q[0] ? emax_q : pmax_q);
  assign dreq.start     = (st_q == StDivGo);
  assign dreq.dividend  = 22'(hp_q[dix_q]) * 22'd100;
  assign dreq.divisor   = dmax;

  // bucket of a finished percentage: percent/20 capped
  logic [2:0] pct_b;
  always_comb begin
    if (drsp.quotient >= 22'd100)     pct_b = 3'(HpBuckets - 1);
    else if (drsp.quotient >= 22'd80) pct_b = 3'd4;
    else if (drsp.quotient >= 22'd60) pct_b = 3'd3;
    else if (drsp.quotient >= 22'd40) pct_b = 3'd2;
    else if (drsp.quotient >= 22'd20) pct_b = 3'd1;
    else                              pct_b = 3'd0;
  end

  // row indexes
  logic [RowW-1:0] prow, nrow;
  assign prow = RowW'(((32'(pd_q) * HpBuckets + 32'(hb_q[0])) * HpBuckets
                + 32'(hb_q[1])) * RoundBuckets + 32'(prd_q));
  assign nrow = RowW'(((32'(nd_q) * HpBuckets + 32'(hb_q[2])) * HpBuckets
                + 32'(hb_q[3])) * RoundBuckets + 32'(nrd_q));

  // Q-table memory
  logic signed [31:0] mem [QDepth];
  logic               mwe;
  logic [AddrW-1:0]   waddr, raddr;
  logic signed [31:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mwe) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [AddrW-1:0]   clr_q;
  logic [4:0]         k_q;
  logic               rvld_q;
  logic signed [31:0] best_q, cur_q, res_q, res_d;
  logic signed [48:0] tgt_q;
  logic signed [49:0] dif_q;
  logic signed [66:0] prod_q;
  logic [AddrW-1:0]   slot;
  logic [31:0]        cnt_q;
  logic               ovld_q;
  logic signed [31:0] onv_q, obest_q;
  logic               oterm_q;
  logic [31:0]        ocnt_q;

  assign slot = AddrW'(32'(prow) * NumActions + 32'(act_q));

  always_comb begin
    raddr = AddrW'(32'(nrow) * NumActions + 32'(k_q));
    if (st_q == StCur || st_q == StTgt) raddr = slot;
  end

  assign mwe   = (st_q == StClear) || (st_q == StWr);
  assign waddr = (st_q == StClear) ? clr_q : slot;
  assign wdata = (st_q == StClear) ? 32'sd0 : res_d;

  // rounded scaling: (x + 2^15) >>> 16 floors, matching halves up
  logic signed [48:0] disc_prod;
  logic signed [66:0] delta_w;
  logic signed [67:0] nv_w;
  assign disc_prod = $signed({1'b0, disc_q}) * best_q;
  assign delta_w   = (prod_q + 67'sd32768) >>> 16;
  assign nv_w      = 68'(cur_q) + 68'(delta_w);

  // saturate the updated entry to the signed 32-bit range
  always_comb begin
    if (nv_w > 68'sh7FFFFFFF) res_d = 32'sh7FFFFFFF;
    else if (nv_w < -68'sh80000000) res_d = 32'sh80000000;
    else res_d = nv_w[31:0];
  end

  logic out_free;
  assign out_free   = !ovld_q || out_ready_i;
  assign in_ready_o = (st_q == StIdle);

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClear: if (clr_q == AddrW'(QDepth - 1)) st_d = StIdle;
      StIdle:  if (in_valid_i) st_d = StDivGo;
      StDivGo: st_d = StDivWt;
      StDivWt: if (drsp.done) st_d = (dix_q == 2'd3) ? StScan : StDivGo;
      StScan:  if (rvld_q && k_q == 5'(NumActions)) st_d = StCur;
      StCur:   st_d = StTgt;
      StTgt:   st_d = StDif;
      StDif:   st_d = StMul;
      StMul:   st_d = StWr;
      StWr:    st_d = StOut;
      StOut:   if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StClear;
      clr_q  <= '0;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
      dix_q  <= '0;
      k_q    <= '0;
      rvld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + AddrW'(1);
      if (st_q == StIdle) begin
        dix_q <= '0;
        k_q   <= '0;
      end
      if (st_q == StDivWt && drsp.done) dix_q <= dix_q + 2'd1;
      // walk the next row, one read in flight
      if (st_q == StScan) begin
        rvld_q <= (k_q < 5'(NumActions));
        if (k_q < 5'(NumActions)) k_q <= k_q + 5'd1;
      end else begin
        rvld_q <= 1'b0;
      end
      if (st_q == StWr) cnt_q <= cnt_q + 32'd1;
      if (st_q == StOut && out_free) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i) begin
      pd_q    <= dist_b(prev_distance_i);
      nd_q    <= dist_b(next_distance_i);
      prd_q   <= round_b(prev_round_i);
      nrd_q   <= round_b(next_round_i);
      act_q   <= (action_taken_i > 4'(NumActions - 1)) ? 4'(NumActions - 1)
                                                     : action_taken_i;
      rew_q   <= reward_i;
      term_q  <= (next_player_hp_i <= 0) || (next_enemy_hp_i <= 0);
      hp_q[0] <= clamp_hp(prev_player_hp_i, fix_max(pmax_q));
      hp_q[1] <= clamp_hp(prev_enemy_hp_i, fix_max(emax_q));
      hp_q[2] <= clamp_hp(next_player_hp_i, fix_max(pmax_q));
      hp_q[3] <= clamp_hp(next_enemy_hp_i, fix_max(emax_q));
    end
    if (st_q == StDivWt && drsp.done) hb_q[dix_q] <= pct_b;
    if (st_q == StScan && rvld_q) begin
      if (k_q == 5'd1 || rdata_q > best_q) best_q <= rdata_q;
    end
    if (st_q == StCur && term_q) best_q <= 32'sd0;
    if (st_q == StTgt) begin
      cur_q <= rdata_q;
      tgt_q <= 49'(rew_q) + ((disc_prod + 49'sd32768) >>> 16);
    end
    if (st_q == StDif) dif_q <= 50'(tgt_q) - 50'(cur_q);
    if (st_q == StMul) prod_q <= $signed({1'b0, lr_q}) * dif_q;
    if (st_q == StWr) res_q <= res_d;
    if (st_q == StOut && out_free) begin
      onv_q   <= res_q;
      obest_q <= best_q;
      oterm_q <= term_q;
      ocnt_q  <= cnt_q;
    end
  end

  assign out_valid_o       = ovld_q;
  assign new_value_o       = onv_q;
  assign next_best_value_o = obest_q;
  assign terminal_o        = oterm_q;
  assign update_count_o    = ocnt_q;

  // no word accepted during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StClear) |-> !in_ready_o) else $error("ready during clear");
  // result register only loads after a write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(st_q == StOut)) else $error("stray result");
  // divider is started only when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider overrun");

endmodule

FILE: hw/rtl/tql_div.sv
// ----------------------------------------------------------------------------
// tql_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tql_div
  import tql_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [21:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [15:0] trial;

  // shift one dividend bit in and try subtracting
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[14:0], quo_q[21]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd21;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[20:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
